FILE: hw/rtl/ardse_pkg.sv
package ardse_pkg;

    localparam int MAX_DIMS_DEF = 6;
    localparam int NUM_INV      = 6;
    localparam int CFG_W        = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int MUL_W        = 64;
    localparam int DIG_W        = 16;
    localparam int DIV_N        = 57;
    localparam int DIV_D        = 24;

    localparam logic [63:0] LOG2E_Q24  = 64'd24204406;
    localparam logic [63:0] LN2_Q32    = 64'd2977044472;
    localparam logic [39:0] JITTER_Q24 = 40'd16777;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [3:0]  HORNER_K0  = 4'd10;

    typedef enum logic [2:0] {
        REG_AMP  = 3'd0,
        REG_DIMS = 3'd1,
        REG_INV0 = 3'd2,
        REG_INV1 = 3'd3,
        REG_INV2 = 3'd4,
        REG_INV3 = 3'd5,
        REG_INV4 = 3'd6,
        REG_INV5 = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {SH_0, SH_16, SH_25, SH_32, SH_40} shift_t;
    typedef enum logic [1:0] {SAT_40, SAT_48, SAT_64} sat_t;

    typedef enum logic [3:0] {
        MOP_NONE, MOP_TERM, MOP_Y, MOP_Z, MOP_HT, MOP_S2, MOP_KV,
        MOP_C3A, MOP_C3, MOP_G1, MOP_LG
    } mop_t;

    typedef enum logic {DOP_HORNER, DOP_SG} dop_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_LOAD, ACT_SQ, ACT_ADVANCE, ACT_HINIT, ACT_EXP, ACT_OUT_LOAD
    } act_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ, ST_TERM_GO, ST_TERM_WAIT, ST_DECIDE,
        ST_Y_GO, ST_Y_WAIT, ST_Z_GO, ST_Z_WAIT, ST_HINIT,
        ST_HT_GO, ST_HT_WAIT, ST_HD_GO, ST_HD_WAIT, ST_EXP,
        ST_S2_GO, ST_S2_WAIT, ST_KV_GO, ST_KV_WAIT, ST_SG_GO, ST_SG_WAIT,
        ST_C3A_GO, ST_C3A_WAIT, ST_C3_GO, ST_C3_WAIT, ST_G1_GO, ST_G1_WAIT,
        ST_LG_GO, ST_LG_WAIT, ST_OUT
    } state_t;

    typedef struct packed {
        logic mul_start;
        logic div_start;
        mop_t mop;
        dop_t dop;
        act_t act;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic close;
        logic horner_last;
        logic emit_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hw/rtl/ardse_mul.sv
module ardse_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ardse_pkg::MUL_W-1:0] op_a,
    input  logic [ardse_pkg::MUL_W-1:0] op_b,
    input  ardse_pkg::shift_t           sh,
    input  ardse_pkg::sat_t             sat,
    output logic                        done,
    output logic [ardse_pkg::MUL_W-1:0] res
);
    localparam int W    = ardse_pkg::MUL_W;
    localparam int D    = ardse_pkg::DIG_W;
    localparam int NDIG = W / D;
    localparam int CW   = $clog2(NDIG + 1);

    logic [W-1:0]     a_reg, b_reg, res_reg;
    logic [2*W-1:0]   acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    ardse_pkg::shift_t sh_reg;
    ardse_pkg::sat_t   sat_reg;

    logic [W+D-1:0]   pp;
    logic [2*W:0]     half, rnd, q, maxv;
    logic [5:0]       sha;

    assign pp = a_reg * b_reg[W-1 -: D];

    // rounding half up, then shift and saturate
    always_comb begin
        unique case (sh_reg)
            ardse_pkg::SH_0:  sha = 6'd0;
            ardse_pkg::SH_16: sha = 6'd16;
            ardse_pkg::SH_25: sha = 6'd25;
            ardse_pkg::SH_32: sha = 6'd32;
            ardse_pkg::SH_40: sha = 6'd40;
            default:          sha = 6'd0;
        endcase
        unique case (sat_reg)
            ardse_pkg::SAT_40: maxv = {{(W+1-40){1'b0}}, {(W-24){1'b1}}, 24'hFF_FFFF} >> (W-40);
            ardse_pkg::SAT_48: maxv = {{(W+1){1'b0}}, {48{1'b1}}, {(W-48){1'b0}}} >> (W-48);
            default:           maxv = {{(W+1){1'b0}}, {W{1'b1}}};
        endcase
        half = (sha == 6'd0) ? '0 : ((2*W+1)'(1) << (sha - 6'd1));
        rnd  = {1'b0, acc_reg} + half;
        q    = rnd >> sha;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NDIG);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            sh_reg  <= sh;
            sat_reg <= sat;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                acc_reg <= {acc_reg[2*W-D-1:0], {D{1'b0}}} + (2*W)'(pp);
                b_reg   <= {b_reg[W-D-1:0], {D{1'b0}}};
            end else begin
                res_reg <= (q > maxv) ? maxv[W-1:0] : q[W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
endmodule

FILE: hw/rtl/ardse_div.sv
module ardse_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ardse_pkg::DIV_N-1:0] dividend,
    input  logic [ardse_pkg::DIV_D-1:0] divisor,
    output logic                        done,
    output logic [ardse_pkg::DIV_N-1:0] quot
);
    localparam int N  = ardse_pkg::DIV_N;
    localparam int DW = ardse_pkg::DIV_D;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial, diff;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[N-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[N-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

FILE: hw/rtl/ardse_dp.sv
module ardse_dp #(
    parameter int MAX_DIMS = ardse_pkg::MAX_DIMS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [ardse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ardse_pkg::CFG_W-1:0]     cfg_data,
    input  logic [47:0]                     s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  ardse_pkg::dp_cmd_t              cmd,
    output ardse_pkg::dp_stat_t             stat,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [127:0]                    m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);
    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int W     = ardse_pkg::MUL_W;

    // configuration
    logic [23:0] amp_reg;
    logic [2:0]  dims_reg;
    logic [23:0] inv_reg [ardse_pkg::NUM_INV];

    // pair state
    logic [23:0]      adiff_reg;
    logic             diag_reg, last_reg;
    logic [47:0]      sqd_reg [MAX_DIMS];
    logic [47:0]      u_reg, sum_reg, y_reg, s2_reg, lg_reg;
    logic [31:0]      z_reg, t_reg;
    logic [32:0]      p_reg, e_reg;
    logic [3:0]       k_reg;
    logic [39:0]      kv_reg, sg_reg;
    logic [55:0]      c3_reg, g1_reg;
    logic [IDX_W-1:0] dim_reg, emit_reg;

    logic [39:0] out_kv_reg, out_sg_reg;
    logic [47:0] out_lg_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg, out_valid_reg;

    logic [24:0] diff;
    logic [23:0] adiff;
    logic [2:0]  inv_addr;
    logic [23:0] inv_q;
    logic [3:0]  lim, n_cur;
    logic [48:0] sum_add;
    logic [40:0] kv_jit;

    logic [W-1:0]        mul_a, mul_b, mul_res;
    ardse_pkg::shift_t   mul_sh;
    ardse_pkg::sat_t     mul_sat;
    logic                mul_done, div_done;
    logic [ardse_pkg::DIV_N-1:0] div_n, div_q;
    logic [ardse_pkg::DIV_D-1:0] div_d;

    assign diff     = {s_axis_tdata[23], s_axis_tdata[23:0]}
                    - {s_axis_tdata[47], s_axis_tdata[47:24]};
    assign adiff    = diff[24] ? 24'(-diff) : diff[23:0];
    assign inv_addr = (cmd.act == ardse_pkg::ACT_SQ) ? 3'(dim_reg) : 3'(emit_reg);
    assign inv_q    = inv_reg[inv_addr];

    always_comb begin
        if (dims_reg == 3'd0) begin
            lim = 4'd1;
        end else if ({1'b0, dims_reg} > 4'(MAX_DIMS)) begin
            lim = 4'(MAX_DIMS);
        end else begin
            lim = {1'b0, dims_reg};
        end
    end
    assign n_cur   = 4'(dim_reg) + 4'd1;
    assign sum_add = {1'b0, sum_reg} + {1'b0, mul_res[47:0]};
    assign kv_jit  = {1'b0, mul_res[39:0]} + (diag_reg ? {1'b0, ardse_pkg::JITTER_Q24} : 41'd0);

    // operand routing for the shared multiplier
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sh  = ardse_pkg::SH_32;
        mul_sat = ardse_pkg::SAT_64;
        unique case (cmd.mop)
            ardse_pkg::MOP_TERM: begin
                mul_a = W'(u_reg); mul_b = W'(u_reg); mul_sat = ardse_pkg::SAT_48;
            end
            ardse_pkg::MOP_Y: begin
                mul_a = W'(sum_reg); mul_b = ardse_pkg::LOG2E_Q24; mul_sh = ardse_pkg::SH_25;
            end
            ardse_pkg::MOP_Z: begin
                mul_a = W'(y_reg[31:0]); mul_b = ardse_pkg::LN2_Q32;
            end
            ardse_pkg::MOP_HT: begin
                mul_a = W'(z_reg); mul_b = W'(p_reg);
            end
            ardse_pkg::MOP_S2: begin
                mul_a = W'(amp_reg); mul_b = W'(amp_reg); mul_sh = ardse_pkg::SH_0;
            end
            ardse_pkg::MOP_KV: begin
                mul_a = W'(s2_reg); mul_b = W'(e_reg);
                mul_sh = ardse_pkg::SH_40; mul_sat = ardse_pkg::SAT_40;
            end
            ardse_pkg::MOP_C3A: begin
                mul_a = W'(inv_q); mul_b = W'(inv_q); mul_sh = ardse_pkg::SH_0;
            end
            ardse_pkg::MOP_C3: begin
                mul_a = W'(c3_reg); mul_b = W'(inv_q); mul_sh = ardse_pkg::SH_16;
            end
            ardse_pkg::MOP_G1: begin
                mul_a = W'(kv_reg); mul_b = W'(sqd_reg[emit_reg]);
            end
            ardse_pkg::MOP_LG: begin
                mul_a = W'(g1_reg); mul_b = W'(c3_reg); mul_sat = ardse_pkg::SAT_48;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.dop == ardse_pkg::DOP_HORNER) begin
            div_n = ardse_pkg::DIV_N'(t_reg) + ardse_pkg::DIV_N'(k_reg >> 1);
            div_d = ardse_pkg::DIV_D'(k_reg);
        end else begin
            div_n = {kv_reg, 17'd0} + ardse_pkg::DIV_N'(amp_reg >> 1);
            div_d = amp_reg;
        end
    end

    ardse_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .sh      (mul_sh),
        .sat     (mul_sat),
        .done    (mul_done),
        .res     (mul_res)
    );

    ardse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_q)
    );

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg       <= 24'd65536;
            dims_reg      <= 3'd1;
            for (int i = 0; i < ardse_pkg::NUM_INV; i++) inv_reg[i] <= 24'd65536;
            sum_reg       <= '0;
            dim_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (ardse_pkg::cfg_reg_t'(cfg_index))
                    ardse_pkg::REG_AMP:  amp_reg    <= cfg_data;
                    ardse_pkg::REG_DIMS: dims_reg   <= cfg_data[2:0];
                    ardse_pkg::REG_INV0: inv_reg[0] <= cfg_data;
                    ardse_pkg::REG_INV1: inv_reg[1] <= cfg_data;
                    ardse_pkg::REG_INV2: inv_reg[2] <= cfg_data;
                    ardse_pkg::REG_INV3: inv_reg[3] <= cfg_data;
                    ardse_pkg::REG_INV4: inv_reg[4] <= cfg_data;
                    ardse_pkg::REG_INV5: inv_reg[5] <= cfg_data;
                    default: ;
                endcase
            end
            if (mul_done && cmd.mop == ardse_pkg::MOP_TERM) begin
                sum_reg <= sum_add[48] ? {48{1'b1}} : sum_add[47:0];
            end
            if (cmd.act == ardse_pkg::ACT_ADVANCE) begin
                dim_reg <= dim_reg + 1'b1;
            end
            if (cmd.act == ardse_pkg::ACT_EXP) begin
                emit_reg <= '0;
            end
            if (cmd.act == ardse_pkg::ACT_OUT_LOAD) begin
                out_valid_reg <= 1'b1;
                if (emit_reg == dim_reg) begin
                    dim_reg  <= '0;
                    sum_reg  <= '0;
                end else begin
                    emit_reg <= emit_reg + 1'b1;
                end
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.act == ardse_pkg::ACT_LOAD) begin
            adiff_reg <= adiff;
            diag_reg  <= s_axis_tuser;
            last_reg  <= s_axis_tlast;
        end
        if (cmd.act == ardse_pkg::ACT_SQ) begin
            sqd_reg[dim_reg] <= adiff_reg * adiff_reg;
            u_reg            <= adiff_reg * inv_q;
        end
        if (cmd.act == ardse_pkg::ACT_HINIT) begin
            p_reg <= ardse_pkg::ONE_Q32;
            k_reg <= ardse_pkg::HORNER_K0;
        end
        if (cmd.act == ardse_pkg::ACT_EXP) begin
            // exp underflows to zero once the integer part passes 32
            e_reg <= (y_reg[47:32] > 16'd32) ? '0 : (p_reg >> y_reg[37:32]);
        end
        if (mul_done) begin
            unique case (cmd.mop)
                ardse_pkg::MOP_Y:   y_reg  <= mul_res[47:0];
                ardse_pkg::MOP_Z:   z_reg  <= mul_res[31:0];
                ardse_pkg::MOP_HT:  t_reg  <= mul_res[31:0];
                ardse_pkg::MOP_S2:  s2_reg <= mul_res[47:0];
                ardse_pkg::MOP_KV:  kv_reg <= kv_jit[40] ? {40{1'b1}} : kv_jit[39:0];
                ardse_pkg::MOP_C3A: c3_reg <= mul_res[55:0];
                ardse_pkg::MOP_C3:  c3_reg <= mul_res[55:0];
                ardse_pkg::MOP_G1:  g1_reg <= mul_res[55:0];
                ardse_pkg::MOP_LG:  lg_reg <= mul_res[47:0];
                default: ;
            endcase
        end
        if (div_done) begin
            if (cmd.dop == ardse_pkg::DOP_HORNER) begin
                p_reg <= ardse_pkg::ONE_Q32 - div_q[32:0];
                k_reg <= k_reg - 1'b1;
            end else begin
                sg_reg <= (div_q[56:40] != '0) ? {40{1'b1}} : div_q[39:0];
            end
        end
        if (cmd.act == ardse_pkg::ACT_OUT_LOAD) begin
            out_kv_reg   <= kv_reg;
            out_sg_reg   <= sg_reg;
            out_lg_reg   <= lg_reg;
            out_idx_reg  <= 3'(emit_reg);
            out_last_reg <= (emit_reg == dim_reg);
        end
    end

    assign stat.mul_done    = mul_done;
    assign stat.div_done    = div_done;
    assign stat.close       = last_reg || (n_cur >= lim);
    assign stat.horner_last = (k_reg == 4'd1);
    assign stat.emit_last   = (emit_reg == dim_reg);
    assign stat.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_lg_reg, out_sg_reg, out_kv_reg};
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule

FILE: hw/rtl/ardse_ctrl.sv
module ardse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  ardse_pkg::dp_stat_t stat,
    output ardse_pkg::dp_cmd_t  cmd
);
    ardse_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ardse_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.div_start = 1'b0;
        cmd.mop       = ardse_pkg::MOP_NONE;
        cmd.dop       = ardse_pkg::DOP_HORNER;
        cmd.act       = ardse_pkg::ACT_NONE;
        unique case (state_reg)
            ardse_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.act    = ardse_pkg::ACT_LOAD;
                    state_next = ardse_pkg::ST_SQ;
                end
            end
            ardse_pkg::ST_SQ: begin
                cmd.act    = ardse_pkg::ACT_SQ;
                state_next = ardse_pkg::ST_TERM_GO;
            end
            ardse_pkg::ST_TERM_GO: begin
                cmd.mop = ardse_pkg::MOP_TERM; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_TERM_WAIT;
            end
            ardse_pkg::ST_TERM_WAIT: begin
                cmd.mop = ardse_pkg::MOP_TERM;
                if (stat.mul_done) state_next = ardse_pkg::ST_DECIDE;
            end
            ardse_pkg::ST_DECIDE: begin
                if (stat.close) begin
                    state_next = ardse_pkg::ST_Y_GO;
                end else begin
                    cmd.act    = ardse_pkg::ACT_ADVANCE;
                    state_next = ardse_pkg::ST_IDLE;
                end
            end
            ardse_pkg::ST_Y_GO: begin
                cmd.mop = ardse_pkg::MOP_Y; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_Y_WAIT;
            end
            ardse_pkg::ST_Y_WAIT: begin
                cmd.mop = ardse_pkg::MOP_Y;
                if (stat.mul_done) state_next = ardse_pkg::ST_Z_GO;
            end
            ardse_pkg::ST_Z_GO: begin
                cmd.mop = ardse_pkg::MOP_Z; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_Z_WAIT;
            end
            ardse_pkg::ST_Z_WAIT: begin
                cmd.mop = ardse_pkg::MOP_Z;
                if (stat.mul_done) state_next = ardse_pkg::ST_HINIT;
            end
            ardse_pkg::ST_HINIT: begin
                cmd.act    = ardse_pkg::ACT_HINIT;
                state_next = ardse_pkg::ST_HT_GO;
            end
            // taylor series for exp(-z), one horner step per pass
            ardse_pkg::ST_HT_GO: begin
                cmd.mop = ardse_pkg::MOP_HT; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_HT_WAIT;
            end
            ardse_pkg::ST_HT_WAIT: begin
                cmd.mop = ardse_pkg::MOP_HT;
                if (stat.mul_done) state_next = ardse_pkg::ST_HD_GO;
            end
            ardse_pkg::ST_HD_GO: begin
                cmd.dop = ardse_pkg::DOP_HORNER; cmd.div_start = 1'b1;
                state_next = ardse_pkg::ST_HD_WAIT;
            end
            ardse_pkg::ST_HD_WAIT: begin
                cmd.dop = ardse_pkg::DOP_HORNER;
                if (stat.div_done) begin
                    state_next = stat.horner_last ? ardse_pkg::ST_EXP : ardse_pkg::ST_HT_GO;
                end
            end
            ardse_pkg::ST_EXP: begin
                cmd.act    = ardse_pkg::ACT_EXP;
                state_next = ardse_pkg::ST_S2_GO;
            end
            ardse_pkg::ST_S2_GO: begin
                cmd.mop = ardse_pkg::MOP_S2; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_S2_WAIT;
            end
            ardse_pkg::ST_S2_WAIT: begin
                cmd.mop = ardse_pkg::MOP_S2;
                if (stat.mul_done) state_next = ardse_pkg::ST_KV_GO;
            end
            ardse_pkg::ST_KV_GO: begin
                cmd.mop = ardse_pkg::MOP_KV; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_KV_WAIT;
            end
            ardse_pkg::ST_KV_WAIT: begin
                cmd.mop = ardse_pkg::MOP_KV;
                if (stat.mul_done) state_next = ardse_pkg::ST_SG_GO;
            end
            // zero amplitude divides to all ones, which saturates as required
            ardse_pkg::ST_SG_GO: begin
                cmd.dop = ardse_pkg::DOP_SG; cmd.div_start = 1'b1;
                state_next = ardse_pkg::ST_SG_WAIT;
            end
            ardse_pkg::ST_SG_WAIT: begin
                cmd.dop = ardse_pkg::DOP_SG;
                if (stat.div_done) state_next = ardse_pkg::ST_C3A_GO;
            end
            ardse_pkg::ST_C3A_GO: begin
                cmd.mop = ardse_pkg::MOP_C3A; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_C3A_WAIT;
            end
            ardse_pkg::ST_C3A_WAIT: begin
                cmd.mop = ardse_pkg::MOP_C3A;
                if (stat.mul_done) state_next = ardse_pkg::ST_C3_GO;
            end
            ardse_pkg::ST_C3_GO: begin
                cmd.mop = ardse_pkg::MOP_C3; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_C3_WAIT;
            end
            ardse_pkg::ST_C3_WAIT: begin
                cmd.mop = ardse_pkg::MOP_C3;
                if (stat.mul_done) state_next = ardse_pkg::ST_G1_GO;
            end
            ardse_pkg::ST_G1_GO: begin
                cmd.mop = ardse_pkg::MOP_G1; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_G1_WAIT;
            end
            ardse_pkg::ST_G1_WAIT: begin
                cmd.mop = ardse_pkg::MOP_G1;
                if (stat.mul_done) state_next = ardse_pkg::ST_LG_GO;
            end
            ardse_pkg::ST_LG_GO: begin
                cmd.mop = ardse_pkg::MOP_LG; cmd.mul_start = 1'b1;
                state_next = ardse_pkg::ST_LG_WAIT;
            end
            ardse_pkg::ST_LG_WAIT: begin
                cmd.mop = ardse_pkg::MOP_LG;
                if (stat.mul_done) state_next = ardse_pkg::ST_OUT;
            end
            ardse_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.act    = ardse_pkg::ACT_OUT_LOAD;
                    state_next = stat.emit_last ? ardse_pkg::ST_IDLE : ardse_pkg::ST_C3A_GO;
                end
            end
            default: state_next = ardse_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: hw/rtl/ard_squared_exponential_kernel.sv
// a non-closing item makes one pass of the shared 64x16 multiplier
// a closing item adds ten horner steps, each using the 57-bit restoring divider,
// then the gradient products for each result
// throughput: one item at a time; the next item is taken once the previous one is done
// reset: synchronous active-low aresetn clears the sequencer, sums and counters and resets the config to its defaults
module ard_squared_exponential_kernel #(
    parameter int MAX_DIMS = ardse_pkg::MAX_DIMS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ardse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ardse_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [47:0]                     s_axis_tdata,  // coord_a, coord_b
    input  logic                            s_axis_tuser,  // on_diagonal
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [127:0]                    m_axis_tdata,  // kernel_value, signal_grad, lengthscale_grad
    output logic [2:0]                      m_axis_tuser,  // dim_index
    output logic                            m_axis_tlast
);
    ardse_pkg::dp_cmd_t  cmd;
    ardse_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ardse_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    ardse_dp #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
